// File: rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    localparam int unsigned HDR_LEN = 5;
    localparam int unsigned HDR_W   = 3;
    localparam int unsigned LEN_W   = 32;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_SEP     = 4'b0010,
        PH_DIGITS  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } res_t;

    function automatic logic [7:0] hdr_char(input logic [HDR_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h49;
            3'd1:    c = 8'h44;
            3'd2:    c = 8'h4F;
            3'd3:    c = 8'h4F;
            3'd4:    c = 8'h52;
            default: c = 8'h49;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage
// Input register: holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module lpfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       byte_vld,
    output logic [7:0] byte_data
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;

    assign in_ready  = !vld_reg || take;
    assign vld_next  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : vld_reg);
    assign byte_vld  = vld_reg;
    assign byte_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

endmodule

// File: rtl/lpfd_core.sv
// ----------------------------------------------------------------------------
// lpfd_core
// Frame state machine: header hunt, separator, length digits, payload count.
// ----------------------------------------------------------------------------
module lpfd_core #(
    parameter int unsigned LENGTH_DIGITS = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic [7:0]      byte_data,
    output logic            res_vld,
    output lpfd_pkg::res_t  res
);

    import lpfd_pkg::*;

    localparam int unsigned CNT_W = $clog2(LENGTH_DIGITS + 1);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [HDR_W-1:0]   hm_reg;
    logic [HDR_W-1:0]   hm_next;
    logic [HDR_W-1:0]   hm_eff;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]   acc_reg;
    logic [LEN_W-1:0]   acc_next;
    logic               inv_reg;
    logic               inv_next;
    logic [LEN_W-1:0]   rem_reg;
    logic [LEN_W-1:0]   rem_next;
    logic               is_digit;
    logic [LEN_W+3:0]   acc_x10;
    logic [LEN_W-1:0]   len_val;

    assign is_digit = (byte_data >= ASCII_ZERO) && (byte_data <= ASCII_NINE);
    assign acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {(LEN_W - 4)'(0), byte_data - ASCII_ZERO};
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign hm_eff   = (hm_reg >= HDR_W'(HDR_LEN)) ? '0 : hm_reg;
    assign len_val  = inv_next ? '0 : acc_next;

    always_comb
    begin
        phase_next = phase_reg;
        hm_next    = hm_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        inv_next   = inv_reg;
        rem_next   = rem_reg;
        res_vld    = 1'b0;
        res.data   = 8'h00;
        res.last   = 1'b0;
        res.empty  = 1'b0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (byte_data == hdr_char(hm_eff))
                begin
                    if (hm_eff == HDR_W'(HDR_LEN - 1))
                    begin
                        hm_next    = '0;
                        phase_next = PH_SEP;
                    end
                    else
                    begin
                        hm_next = hm_eff + HDR_W'(1);
                    end
                end
                else
                begin
                    hm_next = (byte_data == hdr_char('0)) ? HDR_W'(1) : '0;
                end
            end
            PH_SEP:
            begin
                cnt_next   = '0;
                acc_next   = '0;
                inv_next   = 1'b0;
                phase_next = PH_DIGITS;
            end
            PH_DIGITS:
            begin
                if (!is_digit)
                begin
                    inv_next = 1'b1;
                end
                else if (!inv_reg)
                begin
                    if (acc_x10[LEN_W+3:LEN_W] != 4'd0)
                    begin
                        inv_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_x10[LEN_W-1:0];
                    end
                end
                cnt_next = cnt_inc;
                if (cnt_inc >= CNT_W'(LENGTH_DIGITS))
                begin
                    cnt_next = '0;
                    if (len_val == '0)
                    begin
                        phase_next = PH_HUNT;
                        hm_next    = '0;
                        res_vld    = 1'b1;
                        res.last   = 1'b1;
                        res.empty  = 1'b1;
                    end
                    else
                    begin
                        rem_next   = len_val;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - LEN_W'(1);
                end
                res_vld  = 1'b1;
                res.data = byte_data;
                res.last = (rem_reg <= LEN_W'(1));
                if (rem_reg <= LEN_W'(1))
                begin
                    phase_next = PH_HUNT;
                    hm_next    = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                hm_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            hm_reg    <= '0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            inv_reg   <= 1'b0;
            rem_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hm_reg    <= hm_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            inv_reg   <= inv_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// File: rtl/lpfd_out_stage.sv
// ----------------------------------------------------------------------------
// lpfd_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module lpfd_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  lpfd_pkg::res_t  res,
    output logic            out_free,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      payload_byte,
    output logic            last_of_frame,
    output logic            empty_frame
);

    import lpfd_pkg::*;

    logic vld_reg;
    logic vld_next;
    res_t res_reg;

    assign out_free  = !vld_reg || out_ready;
    assign vld_next  = load ? 1'b1 : (out_ready ? 1'b0 : vld_reg);
    assign out_valid = vld_reg;

    assign payload_byte  = res_reg.data;
    assign last_of_frame = res_reg.last;
    assign empty_frame   = res_reg.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: rtl/length_prefixed_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Byte-stream deframer for header-tagged, decimal length-prefixed frames.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the output is not backpressured and gives
// at most one result per byte. A byte passes the input register and the
// frame state machine and lands in the result register, so a result appears
// on the outputs once it is registered there. Header, separator and length
// bytes give no result; the last length byte of a zero-length frame gives one
// item with empty_frame and last_of_frame set. Backpressure on the output
// stalls the input only when the result register is full and not being taken.
module length_prefixed_frame_deframer_unit #(
    parameter int unsigned LENGTH_DIGITS = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] payload_byte,
    output logic       last_of_frame,
    output logic       empty_frame
);

    import lpfd_pkg::*;

    logic       byte_vld;
    logic [7:0] byte_data;
    logic       out_free;
    logic       take;
    logic       res_vld;
    res_t       res;

    assign take = byte_vld && out_free;

    lpfd_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .take      (take),
        .byte_vld  (byte_vld),
        .byte_data (byte_data)
    );

    lpfd_core #(
        .LENGTH_DIGITS (LENGTH_DIGITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_data (byte_data),
        .res_vld   (res_vld),
        .res       (res)
    );

    lpfd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take && res_vld),
        .res           (res),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .empty_frame   (empty_frame)
    );

endmodule
